// ===== design/srtr_pkg.sv =====
package srtr_pkg;

    localparam int CoordBits = 16;
    localparam int GlyphW    = 3;
    localparam int GlyphH    = 5;
    localparam int DotCount  = GlyphW * GlyphH;

    localparam logic [7:0] CharNewline = 8'd10;

    typedef logic [CoordBits-1:0] t_coord;
    typedef logic [DotCount-1:0]  t_rows;
    typedef logic [3:0]           t_dot_idx;

    // one glyph ready for the dot serializer
    typedef struct packed {
        t_coord     base_x;
        t_coord     base_y;
        logic [3:0] dot_size;
        t_rows      rows;
    } t_glyph_job;

    function automatic t_rows g(input logic [2:0] a, input logic [2:0] b,
                                input logic [2:0] c, input logic [2:0] d,
                                input logic [2:0] e);
        return {a, b, c, d, e};
    endfunction

    // 3x5 glyph table, row 0 in the top bits, left column first
    function automatic t_rows glyph_of(input logic [7:0] ch);
        logic [7:0] u;
        u = ch;
        if (ch >= "a" && ch <= "z") begin
            u = ch - 8'd32;
        end
        case (u)
            "A": return g(3'd2, 3'd5, 3'd7, 3'd5, 3'd5);
            "B": return g(3'd6, 3'd5, 3'd6, 3'd5, 3'd6);
            "C": return g(3'd3, 3'd4, 3'd4, 3'd4, 3'd3);
            "D": return g(3'd6, 3'd5, 3'd5, 3'd5, 3'd6);
            "E": return g(3'd7, 3'd4, 3'd6, 3'd4, 3'd7);
            "F": return g(3'd7, 3'd4, 3'd6, 3'd4, 3'd4);
            "G": return g(3'd3, 3'd4, 3'd5, 3'd5, 3'd3);
            "H": return g(3'd5, 3'd5, 3'd7, 3'd5, 3'd5);
            "I": return g(3'd7, 3'd2, 3'd2, 3'd2, 3'd7);
            "J": return g(3'd1, 3'd1, 3'd1, 3'd5, 3'd2);
            "K": return g(3'd5, 3'd5, 3'd6, 3'd5, 3'd5);
            "L": return g(3'd4, 3'd4, 3'd4, 3'd4, 3'd7);
            "M": return g(3'd5, 3'd7, 3'd7, 3'd5, 3'd5);
            "N": return g(3'd5, 3'd7, 3'd7, 3'd7, 3'd5);
            "O": return g(3'd7, 3'd5, 3'd5, 3'd5, 3'd7);
            "P": return g(3'd7, 3'd5, 3'd7, 3'd4, 3'd4);
            "Q": return g(3'd7, 3'd5, 3'd5, 3'd7, 3'd3);
            "R": return g(3'd7, 3'd5, 3'd7, 3'd6, 3'd5);
            "S": return g(3'd3, 3'd4, 3'd7, 3'd1, 3'd6);
            "T": return g(3'd7, 3'd2, 3'd2, 3'd2, 3'd2);
            "U": return g(3'd5, 3'd5, 3'd5, 3'd5, 3'd7);
            "V": return g(3'd5, 3'd5, 3'd5, 3'd5, 3'd2);
            "W": return g(3'd5, 3'd5, 3'd7, 3'd7, 3'd5);
            "X": return g(3'd5, 3'd5, 3'd2, 3'd5, 3'd5);
            "Y": return g(3'd5, 3'd5, 3'd2, 3'd2, 3'd2);
            "Z": return g(3'd7, 3'd1, 3'd2, 3'd4, 3'd7);
            "0": return g(3'd7, 3'd5, 3'd5, 3'd5, 3'd7);
            "1": return g(3'd2, 3'd6, 3'd2, 3'd2, 3'd7);
            "2": return g(3'd7, 3'd1, 3'd7, 3'd4, 3'd7);
            "3": return g(3'd7, 3'd1, 3'd7, 3'd1, 3'd7);
            "4": return g(3'd5, 3'd5, 3'd7, 3'd1, 3'd1);
            "5": return g(3'd7, 3'd4, 3'd7, 3'd1, 3'd7);
            "6": return g(3'd7, 3'd4, 3'd7, 3'd5, 3'd7);
            "7": return g(3'd7, 3'd1, 3'd1, 3'd1, 3'd1);
            "8": return g(3'd7, 3'd5, 3'd7, 3'd5, 3'd7);
            "9": return g(3'd7, 3'd5, 3'd7, 3'd1, 3'd7);
            " ": return '0;
            ".": return g(3'd0, 3'd0, 3'd0, 3'd0, 3'd2);
            ":": return g(3'd0, 3'd2, 3'd0, 3'd2, 3'd0);
            "-": return g(3'd0, 3'd0, 3'd7, 3'd0, 3'd0);
            "_": return g(3'd0, 3'd0, 3'd0, 3'd0, 3'd7);
            "/": return g(3'd1, 3'd1, 3'd2, 3'd4, 3'd4);
            "[": return g(3'd6, 3'd4, 3'd4, 3'd4, 3'd6);
            "]": return g(3'd3, 3'd1, 3'd1, 3'd1, 3'd3);
            "(": return g(3'd2, 3'd4, 3'd4, 3'd4, 3'd2);
            ")": return g(3'd2, 3'd1, 3'd1, 3'd1, 3'd2);
            "<": return g(3'd1, 3'd2, 3'd4, 3'd2, 3'd1);
            ">": return g(3'd4, 3'd2, 3'd1, 3'd2, 3'd4);
            "|": return g(3'd2, 3'd2, 3'd2, 3'd2, 3'd2);
            "=": return g(3'd0, 3'd7, 3'd0, 3'd7, 3'd0);
            "+": return g(3'd0, 3'd2, 3'd7, 3'd2, 3'd0);
            default: return g(3'd7, 3'd5, 3'd2, 3'd0, 3'd2);
        endcase
    endfunction

    // scan position of the first set dot, 0 is top left
    function automatic t_dot_idx first_dot(input t_rows m);
        t_dot_idx k;
        k = '0;
        for (int i = DotCount - 1; i >= 0; i--) begin
            if (m[DotCount-1-i]) begin
                k = t_dot_idx'(i);
            end
        end
        return k;
    endfunction

    // row of a scan position, by compare against row starts
    function automatic logic [2:0] dot_row(input t_dot_idx k);
        logic [2:0] r;
        if (k >= 4'd12) begin
            r = 3'd4;
        end else if (k >= 4'd9) begin
            r = 3'd3;
        end else if (k >= 4'd6) begin
            r = 3'd2;
        end else if (k >= 4'd3) begin
            r = 3'd1;
        end else begin
            r = 3'd0;
        end
        return r;
    endfunction

    function automatic logic [1:0] dot_col(input t_dot_idx k);
        logic [3:0] c;
        c = k - 4'(dot_row(k)) * 4'd3;
        return c[1:0];
    endfunction

    // 16-bit signed field to coordinate width
    function automatic t_coord to_coord(input logic [15:0] v);
        logic signed [31:0] e;
        e = 32'(signed'(v));
        return e[CoordBits-1:0];
    endfunction

    // coordinate to 16-bit signed field
    function automatic logic [15:0] to_out16(input t_coord v);
        logic signed [31:0] e;
        e = 32'(signed'(v));
        return e[15:0];
    endfunction

endpackage

// ===== design/srtr_cursor.sv =====
module srtr_cursor (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  logic [7:0]          i_char_code,
    input  logic                i_first_of_text,
    input  logic [15:0]         i_start_x,
    input  logic [15:0]         i_start_y,
    input  logic [3:0]          i_scale,
    output srtr_pkg::t_glyph_job o_job
);
    import srtr_pkg::*;

    t_coord     r_cursor_x, n_cursor_x;
    t_coord     r_line_x, n_line_x;
    t_coord     r_cursor_y, n_cursor_y;
    t_coord     base_x, base_y, line_x;
    logic [3:0] size;
    logic [6:0] step_y;
    logic [5:0] step_x;
    logic       is_newline;

    always_comb begin
        size       = (i_scale == 4'd0) ? 4'd1 : i_scale;
        step_y     = 7'(size) * 7'd6;
        step_x     = 6'(size) * 6'd4;
        is_newline = (i_char_code == CharNewline);
        base_x     = i_first_of_text ? to_coord(i_start_x) : r_cursor_x;
        line_x     = i_first_of_text ? to_coord(i_start_x) : r_line_x;
        base_y     = i_first_of_text ? to_coord(i_start_y) : r_cursor_y;
    end

    always_comb begin
        n_cursor_x = r_cursor_x;
        n_line_x   = r_line_x;
        n_cursor_y = r_cursor_y;
        if (i_load) begin
            n_line_x = line_x;
            if (is_newline) begin
                n_cursor_x = line_x;
                n_cursor_y = base_y + t_coord'(step_y);
            end else begin
                n_cursor_x = base_x + t_coord'(step_x);
                n_cursor_y = base_y;
            end
        end
    end

    always_comb begin
        o_job.base_x   = base_x;
        o_job.base_y   = base_y;
        o_job.dot_size = size;
        o_job.rows     = is_newline ? '0 : glyph_of(i_char_code);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor_x <= '0;
            r_line_x   <= '0;
            r_cursor_y <= '0;
        end else begin
            r_cursor_x <= n_cursor_x;
            r_line_x   <= n_line_x;
            r_cursor_y <= n_cursor_y;
        end
    end

endmodule

// ===== design/srtr_dot_serializer.sv =====
module srtr_dot_serializer (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  srtr_pkg::t_glyph_job i_job,
    output logic                 o_ready,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic signed [15:0]   o_pixel_x,
    output logic signed [15:0]   o_pixel_y,
    output logic [3:0]           o_dot_size,
    output logic                 o_last_of_glyph
);
    import srtr_pkg::*;

    t_rows      r_mask, n_mask;
    t_coord     r_base_x, r_base_y;
    logic [3:0] r_size;
    logic       r_o_valid;
    logic [15:0] r_px, r_py;
    logic [3:0] r_o_size;
    logic       r_o_last;

    t_dot_idx   k;
    t_rows      rest;
    logic [5:0] off_x;
    logic [6:0] off_y;
    logic       emit;
    logic       busy;

    always_comb begin
        busy    = (r_mask != '0);
        emit    = busy && (!r_o_valid || !i_stall);
        k       = first_dot(r_mask);
        rest    = r_mask & ~(t_rows'(1) << (t_dot_idx'(DotCount - 1) - k));
        off_x   = 6'(dot_col(k)) * 6'(r_size);
        off_y   = 7'(dot_row(k)) * 7'(r_size);
        o_ready = !busy || (emit && (rest == '0));
        n_mask  = r_mask;
        if (emit) begin
            n_mask = rest;
        end
        if (i_load) begin
            n_mask = i_job.rows;
        end
    end

    // glyph register and output word control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_mask <= n_mask;
            if (emit) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_base_x <= i_job.base_x;
            r_base_y <= i_job.base_y;
            r_size   <= i_job.dot_size;
        end
        if (emit) begin
            r_px     <= to_out16(r_base_x + t_coord'(off_x));
            r_py     <= to_out16(r_base_y + t_coord'(off_y));
            r_o_size <= r_size;
            r_o_last <= (rest == '0);
        end
    end

    assign o_valid         = r_o_valid;
    assign o_pixel_x       = signed'(r_px);
    assign o_pixel_y       = signed'(r_py);
    assign o_dot_size      = r_o_size;
    assign o_last_of_glyph = r_o_last;

`ifndef NO_ASSERTIONS
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (r_mask == '0) || (emit && (rest == '0)))
        else $error("glyph loaded over a glyph still in flight");

    a_one_dot_per_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && !i_load) |=> $countones(r_mask) == $countones($past(r_mask)) - 1)
        else $error("emit did not retire exactly one dot");

    a_hold_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy && !emit && !i_load) |=> $stable(r_mask))
        else $error("dot mask changed while output was stalled");

    a_size_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> (r_o_size != 4'd0))
        else $error("zero dot size on output word");
`endif

endmodule

// ===== design/scaled_bitmap_text_rasterizer_unit.sv =====
// scaled 3x5 bitmap text rasterizer: each input word is one character byte
// (lower case folds to upper, unknown bytes draw a question mark) and each
// output word is one filled square of dot_size pixels for a set glyph dot,
// scanned top row first, left to right, with last_of_glyph on the final
// square. newline and space give no output words. the glyph table is read
// into a dot-mask register at acceptance, and one set dot is retired from
// that register per cycle while the output is not stalled, so a character
// holds the serializer until its dots are out (at most 13, for N and 8)
// and a dotless one does not hold it; the next character is taken in the
// cycle its predecessor's last dot leaves. the output register decouples
// the two sides: each square goes from the dot-mask register into it.
module scaled_bitmap_text_rasterizer_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // character words in
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_char_code,
    input  logic               i_first_of_text,
    input  logic signed [15:0] i_start_x,
    input  logic signed [15:0] i_start_y,
    input  logic [3:0]         i_scale,
    // square words out
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_pixel_x,
    output logic signed [15:0] o_pixel_y,
    output logic [3:0]         o_dot_size,
    output logic               o_last_of_glyph
);
    import srtr_pkg::*;

    t_glyph_job job;
    logic       ready;
    logic       load;

    // a character is taken whenever the serializer frees up this cycle
    assign load    = i_valid && ready;
    assign o_stall = !ready;

    // cursor, line start and glyph lookup; cursor advances on acceptance
    srtr_cursor u_cursor (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (load),
        .i_char_code     (i_char_code),
        .i_first_of_text (i_first_of_text),
        .i_start_x       (i_start_x),
        .i_start_y       (i_start_y),
        .i_scale         (i_scale),
        .o_job           (job)
    );

    // glyph register, dot scan and output register
    srtr_dot_serializer u_serializer (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (load),
        .i_job           (job),
        .o_ready         (ready),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_pixel_x       (o_pixel_x),
        .o_pixel_y       (o_pixel_y),
        .o_dot_size      (o_dot_size),
        .o_last_of_glyph (o_last_of_glyph)
    );

endmodule
